FILE: sv/shpc_pkg.sv
// Shared types, constants and the coil pattern table of the stepper homing controller.
package shpc_pkg;

   localparam int PATTERN_LENGTH = 8;
   localparam int IDX_BITS       = $clog2(PATTERN_LENGTH);
   localparam int COUNT_BITS     = 16;
   localparam int WIDE_BITS      = COUNT_BITS + 3;

   localparam int AMOUNT_BITS    = 10;
   localparam int PERIOD_BITS    = 16;
   localparam int CSR_DATA_BITS  = 16;

   localparam int TARGET_MIN     = 10;
   localparam int TARGET_MAX     = 370;
   localparam int ANGLE_LIMIT    = 90;
   localparam int ANGLE_CENTER   = 92;
   localparam int ANGLE_OFFSET   = 2 * ANGLE_CENTER;
   localparam int PERIOD_RESET   = 5000;

   typedef enum logic [1:0] {
      ACT_TICK     = 2'd0,
      ACT_HOME     = 2'd1,
      ACT_MOVE_TO  = 2'd2,
      ACT_MOVE_BY  = 2'd3
   } action_type;

   typedef enum logic {
      CSR_STEP_PERIOD = 1'b0,
      CSR_FULL_STEP   = 1'b1
   } csr_index_type;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [IDX_BITS-1:0]   index_type;

   // Half-step coil sequence, upper nibble of the original port.
   function automatic logic [3:0] coil_pattern(input index_type idx);
      logic [3:0] pat;
      unique case (idx)
         3'd0: pat = 4'b1000;
         3'd1: pat = 4'b1010;
         3'd2: pat = 4'b0010;
         3'd3: pat = 4'b0110;
         3'd4: pat = 4'b0100;
         3'd5: pat = 4'b0101;
         3'd6: pat = 4'b0001;
         3'd7: pat = 4'b1001;
         default: pat = 4'b0000;
      endcase
      return pat;
   endfunction

endpackage

FILE: sv/stepper_homing_position_controller_top.sv
// Stepper homing and position controller: input register, step logic, result register.
//
// Each req item is a timer tick or a command (home, move to angle, move by degrees) and
// yields exactly one rsp item with the coil pattern, status flags, position count and
// angle after that item. An item is taken every cycle when the result side keeps up; it
// is held in the input register, processed there by compare and add logic against the
// motor state, and written into the result register once that register is empty or its
// stall is low. A full result register that is stalled holds one more item in the input
// register before req_stall rises. The csr port sets the step period (ticks between
// motor steps, 0 acts as 1) and half or full stepping; write it only while no item is
// in flight.
module stepper_homing_position_controller_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [1:0]                              req_action,
   input  logic signed [shpc_pkg::AMOUNT_BITS-1:0] req_amount,
   input  logic                                    req_ccw_limit,
   input  logic                                    req_cw_limit,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [3:0]                              rsp_coils,
   output logic                                    rsp_moving,
   output logic                                    rsp_homing_active,
   output logic                                    rsp_homed,
   output logic                                    rsp_limit_fault,
   output logic signed [15:0]                      rsp_position_ticks,
   output logic signed [15:0]                      rsp_angle_now,
   input  logic                                    csr_write_enable,
   input  logic                                    csr_index,
   input  logic [shpc_pkg::CSR_DATA_BITS-1:0]      csr_write_data
);

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_HOME_CW  = 3'd1,
      PH_HOME_CCW = 3'd2,
      PH_CENTER   = 3'd3,
      PH_MOVE     = 3'd4
   } phase_type;

   localparam int CB = shpc_pkg::COUNT_BITS;
   localparam int WB = shpc_pkg::WIDE_BITS;
   localparam int IB = shpc_pkg::IDX_BITS;
   localparam int PB = shpc_pkg::PERIOD_BITS;

   // configuration
   logic [PB-1:0] step_period_ff;
   logic          full_step_ff;

   // input register
   logic                                    s1_valid_ff, s1_valid_in;
   shpc_pkg::action_type                    s1_action_ff;
   logic signed [shpc_pkg::AMOUNT_BITS-1:0] s1_amount_ff;
   logic                                    s1_ccw_ff, s1_cw_ff;

   // motor state
   shpc_pkg::index_type step_index_ff, step_index_in;
   shpc_pkg::index_type index_step_ff, index_step_in;
   shpc_pkg::count_type step_count_ff, step_count_in;
   shpc_pkg::count_type span_count_ff, span_count_in;
   shpc_pkg::count_type target_count_ff, target_count_in;
   logic [PB-1:0]       period_timer_ff, period_timer_in;
   logic                turning_ccw_ff, turning_ccw_in;
   logic                homed_ff, homed_in;
   logic                fault_ff, fault_in;
   logic [3:0]          coil_ff, coil_in;
   phase_type           phase_ff, phase_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         rsp_coils_ff;
   logic               rsp_moving_ff, rsp_homing_ff, rsp_homed_ff, rsp_fault_ff;
   logic signed [15:0] rsp_pos_ff, rsp_angle_ff;

   logic req_accept, advance;

   // step logic signals
   logic                    homing_now, homing_next, period_due;
   logic [IB-1:0]           stride;
   logic signed [WB-1:0]    count_wide, amount_wide, target_raw, target_clamp;
   logic                    angle_ok;
   logic signed [31:0]      count32, half32, angle32;

   assign advance    = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall  = s1_valid_ff & ~advance;
   assign req_accept = req_valid & ~req_stall;
   assign s1_valid_in  = req_accept | (s1_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   assign stride     = full_step_ff ? IB'(2) : IB'(1);
   assign homing_now = (phase_ff == PH_HOME_CW) || (phase_ff == PH_HOME_CCW) ||
                       (phase_ff == PH_CENTER);
   assign period_due = ({1'b0, period_timer_ff} + (PB+1)'(1)) >= {1'b0, step_period_ff};

   assign count_wide  = WB'(signed'(step_count_ff));
   assign amount_wide = WB'(s1_amount_ff);
   assign angle_ok    = (amount_wide >= -WB'(shpc_pkg::ANGLE_LIMIT)) &&
                        (amount_wide <= WB'(shpc_pkg::ANGLE_LIMIT));
   assign target_raw  = (s1_action_ff == shpc_pkg::ACT_MOVE_TO) ?
                        WB'(shpc_pkg::ANGLE_OFFSET) - (amount_wide <<< 1) :
                        count_wide - (amount_wide <<< 1);

   always_comb begin
      if (target_raw > WB'(shpc_pkg::TARGET_MAX)) begin
         target_clamp = WB'(shpc_pkg::TARGET_MAX);
      end else if (target_raw < WB'(shpc_pkg::TARGET_MIN)) begin
         target_clamp = WB'(shpc_pkg::TARGET_MIN);
      end else begin
         target_clamp = target_raw;
      end
   end

   always_comb begin
      step_index_in   = step_index_ff;
      index_step_in   = index_step_ff;
      step_count_in   = step_count_ff;
      span_count_in   = span_count_ff;
      target_count_in = target_count_ff;
      period_timer_in = period_timer_ff;
      turning_ccw_in  = turning_ccw_ff;
      homed_in        = homed_ff;
      fault_in        = fault_ff;
      coil_in         = coil_ff;
      phase_in        = phase_ff;

      unique case (s1_action_ff)
         shpc_pkg::ACT_TICK: begin
            if (phase_ff != PH_IDLE) begin
               if (!period_due) begin
                  period_timer_in = period_timer_ff + PB'(1);
               end else begin
                  period_timer_in = '0;
                  unique case (phase_ff)
                     PH_HOME_CW: begin
                        if (s1_cw_ff) begin
                           // reverse and start measuring the span
                           turning_ccw_in = 1'b1;
                           index_step_in  = IB'(0) - stride;
                           phase_in       = PH_HOME_CCW;
                        end else begin
                           coil_in       = shpc_pkg::coil_pattern(step_index_ff);
                           step_index_in = step_index_ff + index_step_ff;
                           step_count_in = turning_ccw_ff ? step_count_ff - CB'(1) :
                                                            step_count_ff + CB'(1);
                        end
                     end
                     PH_HOME_CCW: begin
                        span_count_in = span_count_ff + CB'(1);
                        if (s1_ccw_ff) begin
                           step_count_in  = '0;
                           turning_ccw_in = 1'b0;
                           index_step_in  = stride;
                           phase_in       = PH_CENTER;
                           if (span_count_in[CB-1:1] == '0) begin
                              phase_in = PH_IDLE;
                              homed_in = 1'b1;
                           end
                        end else begin
                           coil_in       = shpc_pkg::coil_pattern(step_index_ff);
                           step_index_in = step_index_ff + index_step_ff;
                           step_count_in = turning_ccw_ff ? step_count_ff - CB'(1) :
                                                            step_count_ff + CB'(1);
                        end
                     end
                     PH_CENTER: begin
                        coil_in       = shpc_pkg::coil_pattern(step_index_ff);
                        step_index_in = step_index_ff + index_step_ff;
                        step_count_in = turning_ccw_ff ? step_count_ff - CB'(1) :
                                                         step_count_ff + CB'(1);
                        if (step_count_in == {1'b0, span_count_ff[CB-1:1]}) begin
                           phase_in = PH_IDLE;
                           homed_in = 1'b1;
                        end
                     end
                     PH_MOVE: begin
                        if (s1_ccw_ff || s1_cw_ff) begin
                           // abort on any switch and latch the fault
                           fault_in = 1'b1;
                           phase_in = PH_IDLE;
                        end else begin
                           coil_in       = shpc_pkg::coil_pattern(step_index_ff);
                           step_index_in = step_index_ff + index_step_ff;
                           step_count_in = turning_ccw_ff ? step_count_ff - CB'(1) :
                                                            step_count_ff + CB'(1);
                           if (step_count_in == target_count_ff) begin
                              phase_in = PH_IDLE;
                           end
                        end
                     end
                     default: begin
                        phase_in = PH_IDLE;
                     end
                  endcase
               end
            end
         end
         shpc_pkg::ACT_HOME: begin
            phase_in        = PH_HOME_CW;
            turning_ccw_in  = 1'b0;
            index_step_in   = stride;
            span_count_in   = '0;
            homed_in        = 1'b0;
            fault_in        = 1'b0;
            period_timer_in = '0;
         end
         shpc_pkg::ACT_MOVE_TO, shpc_pkg::ACT_MOVE_BY: begin
            if (!homing_now && !fault_ff &&
                (s1_action_ff == shpc_pkg::ACT_MOVE_BY || angle_ok)) begin
               target_count_in = target_clamp[CB-1:0];
               period_timer_in = '0;
               if (target_clamp == count_wide) begin
                  phase_in = PH_IDLE;
               end else begin
                  turning_ccw_in = target_clamp < count_wide;
                  index_step_in  = (target_clamp < count_wide) ? IB'(0) - stride : stride;
                  phase_in       = PH_MOVE;
               end
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   assign homing_next = (phase_in == PH_HOME_CW) || (phase_in == PH_HOME_CCW) ||
                        (phase_in == PH_CENTER);
   assign count32 = 32'(signed'(step_count_in));
   // divide by two, truncating toward zero
   assign half32  = (count32 + {31'd0, count32[31]}) >>> 1;
   assign angle32 = 32'(shpc_pkg::ANGLE_CENTER) - half32;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_period_ff  <= PB'(shpc_pkg::PERIOD_RESET);
         full_step_ff    <= 1'b0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         step_index_ff   <= '0;
         index_step_ff   <= IB'(1);
         step_count_ff   <= '0;
         span_count_ff   <= '0;
         target_count_ff <= '0;
         period_timer_ff <= '0;
         turning_ccw_ff  <= 1'b0;
         homed_ff        <= 1'b0;
         fault_ff        <= 1'b0;
         coil_ff         <= '0;
         phase_ff        <= PH_IDLE;
      end else begin
         if (csr_write_enable) begin
            unique case (shpc_pkg::csr_index_type'(csr_index))
               shpc_pkg::CSR_STEP_PERIOD: step_period_ff <= csr_write_data[PB-1:0];
               shpc_pkg::CSR_FULL_STEP:   full_step_ff   <= csr_write_data[0];
               default:                   full_step_ff   <= full_step_ff;
            endcase
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            step_index_ff   <= step_index_in;
            index_step_ff   <= index_step_in;
            step_count_ff   <= step_count_in;
            span_count_ff   <= span_count_in;
            target_count_ff <= target_count_in;
            period_timer_ff <= period_timer_in;
            turning_ccw_ff  <= turning_ccw_in;
            homed_ff        <= homed_in;
            fault_ff        <= fault_in;
            coil_ff         <= coil_in;
            phase_ff        <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_action_ff <= shpc_pkg::action_type'(req_action);
         s1_amount_ff <= req_amount;
         s1_ccw_ff    <= req_ccw_limit;
         s1_cw_ff     <= req_cw_limit;
      end
      if (advance) begin
         rsp_coils_ff  <= coil_in;
         rsp_moving_ff <= phase_in != PH_IDLE;
         rsp_homing_ff <= homing_next;
         rsp_homed_ff  <= homed_in;
         rsp_fault_ff  <= fault_in;
         rsp_pos_ff    <= count32[15:0];
         rsp_angle_ff  <= angle32[15:0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_coils          = rsp_coils_ff;
   assign rsp_moving         = rsp_moving_ff;
   assign rsp_homing_active  = rsp_homing_ff;
   assign rsp_homed          = rsp_homed_ff;
   assign rsp_limit_fault    = rsp_fault_ff;
   assign rsp_position_ticks = rsp_pos_ff;
   assign rsp_angle_now      = rsp_angle_ff;

endmodule
